// ===== rtl/i2cm10_pkg.sv =====
// Shared types and constants for the ten-bit address I2C master sequencer.
// No dependencies; every rtl file refers to this package by scoped names.
package i2cm10_pkg;

  localparam int ADDR_W    = 10;
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 3;
  localparam int PHASE_W   = 3;
  localparam int IDX_W     = 2;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Default byte counts for the two transfer modes.
  localparam int WRITE_BYTES_DEF       = 3;
  localparam int READ_PREFIX_BYTES_DEF = 2;

  // Event kinds.
  localparam logic [KIND_W-1:0] KIND_BEGIN_WR = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN_RD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACK      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NACK     = 3'd4;

  // Transaction phases.
  localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HWR    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LADDR  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DATA   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RSTART = 3'd4;
  localparam logic [PHASE_W-1:0] PH_HRD    = 3'd5;
  localparam logic [PHASE_W-1:0] PH_RDATA  = 3'd6;
  localparam logic [PHASE_W-1:0] PH_STOP   = 3'd7;

  // Bus actions.
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_GO    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_START = 2'd2;
  localparam logic [ACT_W-1:0] ACT_STOP  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BYTE_0    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BYTE_1    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BYTE_2    = 2'd3;

  // Upper five bits of a ten-bit address header: 11110.
  localparam logic [BYTE_W-1:0] HEADER_MARK = 8'hF0;

  typedef struct packed {
    logic [ADDR_W-1:0] slave_address;
    logic [BYTE_W-1:0] out_byte_0;
    logic [BYTE_W-1:0] out_byte_1;
    logic [BYTE_W-1:0] out_byte_2;
  } cfg_t;

  typedef struct packed {
    logic               read_mode;
    logic [PHASE_W-1:0] phase;
    logic [IDX_W-1:0]   byte_index;
  } seq_state_t;

  typedef struct packed {
    logic              load_tx;
    logic [BYTE_W-1:0] tx_byte;
    logic [ACT_W-1:0]  bus_action;
    logic              done_res;
    logic [BYTE_W-1:0] rx_data;
  } result_t;

endpackage

// ===== rtl/i2cm10_cfg.sv =====
// Configuration register file: slave address and the three data bytes.
// Depends on i2cm10_pkg.
module i2cm10_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [i2cm10_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [i2cm10_pkg::ADDR_W-1:0]        wr_data,
  output i2cm10_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        i2cm10_pkg::REG_SLAVE_ADDRESS: cfg.slave_address <= wr_data;
        i2cm10_pkg::REG_OUT_BYTE_0: cfg.out_byte_0 <= wr_data[i2cm10_pkg::BYTE_W-1:0];
        i2cm10_pkg::REG_OUT_BYTE_1: cfg.out_byte_1 <= wr_data[i2cm10_pkg::BYTE_W-1:0];
        i2cm10_pkg::REG_OUT_BYTE_2: cfg.out_byte_2 <= wr_data[i2cm10_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/i2cm10_step.sv =====
// Next-phase and result logic for one bus event.
// Depends on i2cm10_pkg; purely combinational.
module i2cm10_step #(
  parameter int WRITE_BYTES       = i2cm10_pkg::WRITE_BYTES_DEF,
  parameter int READ_PREFIX_BYTES = i2cm10_pkg::READ_PREFIX_BYTES_DEF
) (
  input  i2cm10_pkg::cfg_t                   cfg,
  input  i2cm10_pkg::seq_state_t             cur,
  input  logic [i2cm10_pkg::KIND_W-1:0]      kind,
  input  logic [i2cm10_pkg::BYTE_W-1:0]      received_byte,
  output i2cm10_pkg::seq_state_t             nxt,
  output i2cm10_pkg::result_t                res
);

  localparam logic [i2cm10_pkg::IDX_W-1:0] WR_LIMIT = i2cm10_pkg::IDX_W'(WRITE_BYTES);
  localparam logic [i2cm10_pkg::IDX_W-1:0] RD_LIMIT = i2cm10_pkg::IDX_W'(READ_PREFIX_BYTES);

  logic [i2cm10_pkg::BYTE_W-1:0] data_byte;
  logic [i2cm10_pkg::BYTE_W-1:0] hdr_wr;
  logic [i2cm10_pkg::BYTE_W-1:0] hdr_rd;
  logic [i2cm10_pkg::IDX_W-1:0]  limit;
  logic [i2cm10_pkg::IDX_W-1:0]  index_inc;

  assign hdr_wr    = i2cm10_pkg::HEADER_MARK
                   | {5'd0, cfg.slave_address[i2cm10_pkg::ADDR_W-1:i2cm10_pkg::BYTE_W], 1'b0};
  assign hdr_rd    = hdr_wr | 8'h01;
  assign limit     = cur.read_mode ? RD_LIMIT : WR_LIMIT;
  assign index_inc = cur.byte_index + 2'd1;

  always_comb begin
    case (cur.byte_index)
      2'd0:    data_byte = cfg.out_byte_0;
      2'd1:    data_byte = cfg.out_byte_1;
      2'd2:    data_byte = cfg.out_byte_2;
      default: data_byte = '0;
    endcase
  end

  always_comb begin
    nxt = cur;
    res = '0;
    case (kind)
      i2cm10_pkg::KIND_BEGIN_WR, i2cm10_pkg::KIND_BEGIN_RD: begin
        nxt.read_mode  = kind[0];
        nxt.phase      = i2cm10_pkg::PH_START;
        nxt.byte_index = '0;
        res.bus_action = i2cm10_pkg::ACT_START;
      end
      i2cm10_pkg::KIND_START: begin
        res.bus_action = i2cm10_pkg::ACT_GO;
        if (!cur.read_mode || cur.phase == i2cm10_pkg::PH_START) begin
          res.load_tx = 1'b1;
          res.tx_byte = hdr_wr;
          nxt.phase   = i2cm10_pkg::PH_HWR;
        end else if (cur.phase == i2cm10_pkg::PH_RSTART) begin
          res.load_tx = 1'b1;
          res.tx_byte = hdr_rd;
          nxt.phase   = i2cm10_pkg::PH_HRD;
        end
      end
      i2cm10_pkg::KIND_ACK: begin
        if (cur.phase == i2cm10_pkg::PH_HWR) begin
          res.load_tx    = 1'b1;
          res.tx_byte    = cfg.slave_address[i2cm10_pkg::BYTE_W-1:0];
          res.bus_action = i2cm10_pkg::ACT_GO;
          nxt.phase      = i2cm10_pkg::PH_LADDR;
        end else if (cur.phase == i2cm10_pkg::PH_LADDR) begin
          res.load_tx    = 1'b1;
          res.tx_byte    = data_byte;
          res.bus_action = i2cm10_pkg::ACT_GO;
          nxt.phase      = i2cm10_pkg::PH_DATA;
          nxt.byte_index = index_inc;
        end else if (cur.phase == i2cm10_pkg::PH_DATA) begin
          if (cur.byte_index != limit) begin
            res.load_tx    = 1'b1;
            res.tx_byte    = data_byte;
            res.bus_action = i2cm10_pkg::ACT_GO;
            nxt.byte_index = index_inc;
          end else if (cur.read_mode) begin
            res.bus_action = i2cm10_pkg::ACT_START;
            nxt.phase      = i2cm10_pkg::PH_RSTART;
          end else begin
            res.done_res   = 1'b1;
            res.bus_action = i2cm10_pkg::ACT_STOP;
            nxt.phase      = i2cm10_pkg::PH_STOP;
          end
        end else if (cur.read_mode && cur.phase == i2cm10_pkg::PH_HRD) begin
          res.bus_action = i2cm10_pkg::ACT_GO;
          nxt.phase      = i2cm10_pkg::PH_RDATA;
        end
      end
      i2cm10_pkg::KIND_NACK: begin
        if (cur.phase == i2cm10_pkg::PH_HWR) begin
          res.bus_action = i2cm10_pkg::ACT_START;
          nxt.phase      = i2cm10_pkg::PH_START;
        end else if (cur.phase == i2cm10_pkg::PH_LADDR
                     || (!cur.read_mode && cur.phase == i2cm10_pkg::PH_DATA)) begin
          res.bus_action = i2cm10_pkg::ACT_STOP;
          nxt.phase      = i2cm10_pkg::PH_STOP;
        end else if (cur.read_mode && cur.phase == i2cm10_pkg::PH_RDATA) begin
          res.rx_data    = received_byte;
          res.done_res   = 1'b1;
          res.bus_action = i2cm10_pkg::ACT_STOP;
          nxt.phase      = i2cm10_pkg::PH_STOP;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/i2cm10_out_reg.sv =====
// Result register for the output channel, with its valid flag.
// Depends on i2cm10_pkg.
module i2cm10_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  i2cm10_pkg::result_t  res_in,
  input  logic                 out_stall,
  output logic                 out_valid,
  output i2cm10_pkg::result_t  res_out
);

  logic out_valid_next;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Payload holds unless a new beat is loaded.
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== rtl/i2c_master_10bit_sequencer_core.sv =====
// Top level of the ten-bit address I2C master sequencer.
// Depends on i2cm10_pkg, i2cm10_cfg, i2cm10_step and i2cm10_out_reg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  cfg     | in        | wr_en                | wr_index, wr_data
//  in      | in        | in_valid / in_stall  | kind, received_byte
//  out     | out       | out_valid / out_stall| load_tx, tx_byte, bus_action, done_res,
//          |           |                      | rx_data
//
// Each accepted input beat yields exactly one output beat, in the following cycle.
// The phase register updates on the accept edge and the result lands in the
// output register, so a new beat can enter every cycle in which in_stall is low:
// throughput is one beat per clock, set by the single phase/index register loop.
// in_stall rises only while a result sits unclaimed and out_stall is high.
// rst is synchronous: write mode, send-start phase, index zero, config and out_valid zero.
module i2c_master_10bit_sequencer_core #(
  parameter int WRITE_BYTES       = i2cm10_pkg::WRITE_BYTES_DEF,
  parameter int READ_PREFIX_BYTES = i2cm10_pkg::READ_PREFIX_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                wr_en,
  input  logic [i2cm10_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [i2cm10_pkg::ADDR_W-1:0]       wr_data,
  // event input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [i2cm10_pkg::KIND_W-1:0]       kind,
  input  logic [i2cm10_pkg::BYTE_W-1:0]       received_byte,
  // result output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                load_tx,
  output logic [i2cm10_pkg::BYTE_W-1:0]       tx_byte,
  output logic [i2cm10_pkg::ACT_W-1:0]        bus_action,
  output logic                                done_res,
  output logic [i2cm10_pkg::BYTE_W-1:0]       rx_data
);

  i2cm10_pkg::cfg_t       cfg;
  i2cm10_pkg::seq_state_t seq_state;
  i2cm10_pkg::seq_state_t seq_state_next;
  i2cm10_pkg::result_t    step_res;
  i2cm10_pkg::result_t    out_res;
  logic                   in_accept;

  // Stall the input only when the result register is full and not draining.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  i2cm10_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  i2cm10_step #(
    .WRITE_BYTES       (WRITE_BYTES),
    .READ_PREFIX_BYTES (READ_PREFIX_BYTES)
  ) u_step (
    .cfg           (cfg),
    .cur           (seq_state),
    .kind          (kind),
    .received_byte (received_byte),
    .nxt           (seq_state_next),
    .res           (step_res)
  );

  // Advance the phase, mode and byte index on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state.read_mode  <= 1'b0;
      seq_state.phase      <= i2cm10_pkg::PH_START;
      seq_state.byte_index <= '0;
    end else if (in_accept) begin
      seq_state <= seq_state_next;
    end
  end

  i2cm10_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept),
    .res_in    (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign load_tx    = out_res.load_tx;
  assign tx_byte    = out_res.tx_byte;
  assign bus_action = out_res.bus_action;
  assign done_res   = out_res.done_res;
  assign rx_data    = out_res.rx_data;

  // An accepted beat always shows up at the output on the next cycle.
  a_accept_to_out: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted beat did not reach the output register");

  // Backpressure only while a result is held.
  a_stall_needs_valid: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // Completion always comes with a stop.
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (bus_action == i2cm10_pkg::ACT_STOP))
    else $error("done without stop action");

  // Nothing to transmit means a zero byte.
  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !load_tx) |-> (tx_byte == '0))
    else $error("tx_byte nonzero without load_tx");

endmodule
